// File: sv/tfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants of the tile file name parser
// Character classes, result word, register indexes, extension table and
// queue sizes used by the front, back and result queue.
// ----------------------------------------------------------------------------
package tfp_pkg;

	// magnitude range of easting and northing: signed COORD_BITS values
	localparam int COORD_BITS = 32;
	localparam int ACC_W      = COORD_BITS;
	localparam int PROD_W     = ACC_W + 4;

	// fixed field widths
	localparam int CHAR_W  = 8;
	localparam int LOD_W   = 8;
	localparam int COORD_W = 32;
	localparam int MIN_W   = 4;
	localparam int DCNT_W  = 5;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LOD_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COORD_MIN = 2'd1;

	localparam logic [MIN_W-1:0] LOD_MIN_RESET   = 4'd1;
	localparam logic [MIN_W-1:0] COORD_MIN_RESET = 4'd7;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	localparam logic [LOD_W-1:0] LOD_MAX = 8'd255;

	// extension candidates: meta, bin, jpg
	localparam int EXT_NUM   = 3;
	localparam int EXT_POS_W = 3;
	localparam logic [CHAR_W-1:0] EXT_TEXT [EXT_NUM][4] = '{
		'{8'h6d, 8'h65, 8'h74, 8'h61},
		'{8'h62, 8'h69, 8'h6e, 8'h00},
		'{8'h6a, 8'h70, 8'h67, 8'h00}
	};
	localparam logic [EXT_POS_W-1:0] EXT_LEN [EXT_NUM] = '{3'd4, 3'd3, 3'd3};

	typedef enum logic [1:0] {
		KIND_META = 2'd0,
		KIND_BIN  = 2'd1,
		KIND_JPG  = 2'd2
	} kind_t;

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_LOD   = 4'b0001,
		PH_EAST  = 4'b0010,
		PH_NORTH = 4'b0100,
		PH_EXT   = 4'b1000
	} phase_t;

	// queue between front and back
	localparam int MQ_AW    = 2;
	localparam int MQ_DEPTH = 1 << MQ_AW;
	localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);

	// result queue
	localparam int OQ_AW    = 1;
	localparam int OQ_DEPTH = 1 << OQ_AW;
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              is_digit;
		logic [3:0]        digit;
		logic              is_minus;
		logic              is_dot;
		logic              is_zero;
		logic              last;
	} class_t;

	typedef struct packed {
		logic               valid;
		logic [LOD_W-1:0]   lod;
		logic [COORD_W-1:0] east;
		logic [COORD_W-1:0] north;
		logic [1:0]         kind;
	} result_t;

	typedef struct packed {
		logic                 write;
		logic [CFG_IDX_W-1:0] index;
		logic [MIN_W-1:0]     data;
	} cfg_wr_t;

endpackage

// File: sv/tfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_front: character intake
// Classify each accepted character and hold the classified words in a
// short queue until the back takes them.
// ----------------------------------------------------------------------------
module tfp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [tfp_pkg::CHAR_W-1:0]   character,
	input  logic                         last_char,
	output tfp_pkg::class_t              word,
	output logic                         avail,
	input  logic                         take
);

	tfp_pkg::class_t                  mem_q [tfp_pkg::MQ_DEPTH];
	logic [tfp_pkg::MQ_AW-1:0]        wr_ptr_q;
	logic [tfp_pkg::MQ_AW-1:0]        rd_ptr_q;
	logic [tfp_pkg::MQ_CW-1:0]        count_q;
	tfp_pkg::class_t                  cls;
	logic                             do_push;
	logic                             do_pop;

	always_comb begin
		cls.code     = character;
		cls.is_digit = character inside {[tfp_pkg::CH_0:tfp_pkg::CH_9]};
		cls.digit    = character[3:0];
		cls.is_minus = (character == tfp_pkg::CH_MINUS);
		cls.is_dot   = (character == tfp_pkg::CH_DOT);
		cls.is_zero  = (character == tfp_pkg::CH_NUL);
		cls.last     = last_char;
	end

	assign full    = (count_q == tfp_pkg::MQ_CW'(tfp_pkg::MQ_DEPTH));
	assign avail   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = take && avail;
	assign word    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= tfp_pkg::MQ_AW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= tfp_pkg::MQ_AW'(rd_ptr_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= tfp_pkg::MQ_CW'(count_q + 1'b1);
				2'b01:   count_q <= tfp_pkg::MQ_CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/tfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_back: parse engine
// Advance the number and extension state by one classified character per
// cycle; a name end waits for room in the result queue and emits one result.
// ----------------------------------------------------------------------------
module tfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tfp_pkg::cfg_wr_t    cfg,
	input  tfp_pkg::class_t     word,
	input  logic                avail,
	output logic                take,
	input  logic                res_full,
	output logic                res_put,
	output tfp_pkg::result_t    res
);

	tfp_pkg::phase_t                  phase_q, phase_d;
	logic [tfp_pkg::DCNT_W-1:0]       digit_count_q, digit_count_d;
	logic                             lead_zero_q, lead_zero_d;
	logic                             minus_q, minus_d;
	logic [tfp_pkg::ACC_W-1:0]        acc_q, acc_d;
	logic [tfp_pkg::LOD_W-1:0]        lod_q, lod_d;
	logic [tfp_pkg::COORD_W-1:0]      east_q, east_d;
	logic [tfp_pkg::COORD_W-1:0]      north_q, north_d;
	logic [tfp_pkg::EXT_NUM-1:0]      ext_open_q, ext_open_d;
	logic [tfp_pkg::EXT_POS_W-1:0]    ext_pos_q, ext_pos_d;
	logic                             failed_q, failed_d;
	logic                             ended_q, ended_d;
	logic [tfp_pkg::MIN_W-1:0]        lod_min_q;
	logic [tfp_pkg::MIN_W-1:0]        coord_min_q;

	logic                             gives;
	logic [tfp_pkg::ACC_W-1:0]        lim;
	logic [tfp_pkg::PROD_W-1:0]       prod;
	logic                             ovf;
	logic [tfp_pkg::MIN_W-1:0]        minw_base;
	logic [tfp_pkg::DCNT_W-1:0]       minw;
	logic                             term_ok;
	logic signed [tfp_pkg::ACC_W:0]   mag;
	logic signed [tfp_pkg::ACC_W:0]   sval;
	logic                             found;
	logic [1:0]                       kind;

	// a word that ends a name needs room in the result queue
	assign gives = !ended_q && (word.is_zero || word.last);
	assign take  = avail && (!gives || !res_full);

	always_comb begin
		if (phase_q == tfp_pkg::PH_LOD) begin
			lim = minus_q ? '0 : tfp_pkg::ACC_W'(tfp_pkg::LOD_MAX);
		end else if (minus_q) begin
			lim = tfp_pkg::ACC_W'(1) << (tfp_pkg::COORD_BITS - 1);
		end else begin
			lim = (tfp_pkg::ACC_W'(1) << (tfp_pkg::COORD_BITS - 1)) - 1'b1;
		end
		// times ten as shift and add
		prod = tfp_pkg::PROD_W'({acc_q, 3'b000}) + tfp_pkg::PROD_W'({acc_q, 1'b0})
			+ tfp_pkg::PROD_W'(word.digit);
		ovf = prod > tfp_pkg::PROD_W'(lim);

		minw_base = (phase_q == tfp_pkg::PH_LOD) ? lod_min_q : coord_min_q;
		if (minus_q) begin
			minw = (minw_base > 4'd1) ? tfp_pkg::DCNT_W'(minw_base - 4'd1)
				: tfp_pkg::DCNT_W'(1);
		end else begin
			minw = tfp_pkg::DCNT_W'(minw_base);
		end
		term_ok = (phase_q == tfp_pkg::PH_NORTH) ? word.is_dot : word.is_minus;
		mag  = {1'b0, acc_q};
		sval = minus_q ? -mag : mag;
	end

	always_comb begin
		phase_d       = phase_q;
		digit_count_d = digit_count_q;
		lead_zero_d   = lead_zero_q;
		minus_d       = minus_q;
		acc_d         = acc_q;
		lod_d         = lod_q;
		east_d        = east_q;
		north_d       = north_q;
		ext_open_d    = ext_open_q;
		ext_pos_d     = ext_pos_q;
		failed_d      = failed_q;
		ended_d       = ended_q;
		res_put       = 1'b0;
		res           = '0;
		found         = 1'b0;
		kind          = tfp_pkg::KIND_META;

		if (take) begin
			if (ended_q) begin
				// drop bytes until the last one, then clear
				if (word.last) begin
					ended_d = 1'b0;
				end
			end else begin
				if (!word.is_zero) begin
					if (phase_q != tfp_pkg::PH_EXT) begin
						if (word.is_minus && digit_count_q == '0 && !minus_q) begin
							minus_d = 1'b1;
						end else if (word.is_digit) begin
							if (digit_count_q == '0 && word.digit == 4'd0) begin
								lead_zero_d = 1'b1;
							end
							if (ovf) begin
								failed_d = 1'b1;
							end else begin
								acc_d = prod[tfp_pkg::ACC_W-1:0];
							end
							if (digit_count_q != '1) begin
								digit_count_d = tfp_pkg::DCNT_W'(digit_count_q + 1'b1);
							end
						end else begin
							// number ends here
							if (digit_count_q < minw) failed_d = 1'b1;
							if (lead_zero_q && digit_count_q > minw) failed_d = 1'b1;
							if (minus_q && acc_q == '0) failed_d = 1'b1;
							if (!term_ok) failed_d = 1'b1;
							case (phase_q)
								tfp_pkg::PH_LOD: begin
									lod_d   = acc_q[tfp_pkg::LOD_W-1:0];
									phase_d = tfp_pkg::PH_EAST;
								end
								tfp_pkg::PH_EAST: begin
									east_d  = tfp_pkg::COORD_W'(sval);
									phase_d = tfp_pkg::PH_NORTH;
								end
								default: begin
									north_d = tfp_pkg::COORD_W'(sval);
									phase_d = tfp_pkg::PH_EXT;
								end
							endcase
							digit_count_d = '0;
							lead_zero_d   = 1'b0;
							minus_d       = 1'b0;
							acc_d         = '0;
						end
					end else begin
						for (int k = 0; k < tfp_pkg::EXT_NUM; k++) begin
							if (ext_open_q[k] && (ext_pos_q >= tfp_pkg::EXT_LEN[k]
								|| tfp_pkg::EXT_TEXT[k][ext_pos_q[1:0]] != word.code)) begin
								ext_open_d[k] = 1'b0;
							end
						end
						if (ext_pos_q != '1) begin
							ext_pos_d = tfp_pkg::EXT_POS_W'(ext_pos_q + 1'b1);
						end
					end
				end

				if (word.is_zero || word.last) begin
					if (phase_d == tfp_pkg::PH_EXT) begin
						for (int k = tfp_pkg::EXT_NUM - 1; k >= 0; k--) begin
							if (ext_open_d[k] && ext_pos_d == tfp_pkg::EXT_LEN[k]) begin
								found = 1'b1;
								kind  = 2'(k);
							end
						end
					end
					res_put = 1'b1;
					if (found && !failed_d) begin
						res.valid = 1'b1;
						res.lod   = lod_d;
						res.east  = east_d;
						res.north = north_d;
						res.kind  = kind;
					end
					phase_d       = tfp_pkg::PH_LOD;
					digit_count_d = '0;
					lead_zero_d   = 1'b0;
					minus_d       = 1'b0;
					acc_d         = '0;
					lod_d         = '0;
					east_d        = '0;
					north_d       = '0;
					ext_open_d    = '1;
					ext_pos_d     = '0;
					failed_d      = 1'b0;
					ended_d       = !word.last;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tfp_pkg::PH_LOD;
			digit_count_q <= '0;
			lead_zero_q   <= 1'b0;
			minus_q       <= 1'b0;
			acc_q         <= '0;
			lod_q         <= '0;
			east_q        <= '0;
			north_q       <= '0;
			ext_open_q    <= '1;
			ext_pos_q     <= '0;
			failed_q      <= 1'b0;
			ended_q       <= 1'b0;
			lod_min_q     <= tfp_pkg::LOD_MIN_RESET;
			coord_min_q   <= tfp_pkg::COORD_MIN_RESET;
		end else begin
			phase_q       <= phase_d;
			digit_count_q <= digit_count_d;
			lead_zero_q   <= lead_zero_d;
			minus_q       <= minus_d;
			acc_q         <= acc_d;
			lod_q         <= lod_d;
			east_q        <= east_d;
			north_q       <= north_d;
			ext_open_q    <= ext_open_d;
			ext_pos_q     <= ext_pos_d;
			failed_q      <= failed_d;
			ended_q       <= ended_d;
			if (cfg.write) begin
				case (cfg.index)
					tfp_pkg::REG_LOD_MIN:   lod_min_q   <= cfg.data;
					tfp_pkg::REG_COORD_MIN: coord_min_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: sv/tfp_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_out_queue: result queue
// Hold finished result words until the consumer pops them.
// ----------------------------------------------------------------------------
module tfp_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               put,
	input  tfp_pkg::result_t   res_in,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output tfp_pkg::result_t   res_out
);

	tfp_pkg::result_t            mem_q [tfp_pkg::OQ_DEPTH];
	logic [tfp_pkg::OQ_AW-1:0]   wr_ptr_q;
	logic [tfp_pkg::OQ_AW-1:0]   rd_ptr_q;
	logic [tfp_pkg::OQ_CW-1:0]   count_q;
	logic                        do_put;
	logic                        do_pop;

	assign full    = (count_q == tfp_pkg::OQ_CW'(tfp_pkg::OQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_put  = put && !full;
	assign do_pop  = pop && !empty;
	assign res_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_put) begin
			mem_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_put) begin
				wr_ptr_q <= tfp_pkg::OQ_AW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= tfp_pkg::OQ_AW'(rd_ptr_q + 1'b1);
			end
			case ({do_put, do_pop})
				2'b10:   count_q <= tfp_pkg::OQ_CW'(count_q + 1'b1);
				2'b01:   count_q <= tfp_pkg::OQ_CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/tile_filename_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_filename_parser_core: streaming tile file name parser
// Parse "lod-easting-northing.ext" one character per word and report the
// three numbers and the file kind when the name ends.
// ----------------------------------------------------------------------------
// Push the name one byte per word, first byte first; mark the final byte
// with last_char, or end the name early with a zero byte. The block takes a
// word every cycle while full is low: one character per cycle sustained
// while the result queue has room, set by the parse step in the back end
// (a times-ten shift-add and range compare on the accumulator). The word
// ending the name waits in the character queue; when the back end takes it,
// its result word is written into the result queue and reaches the result
// ports at the head of that queue, where it stays until popped. Each name
// gives exactly one result; bytes after a zero byte are dropped up to and
// including the byte marked last. An invalid name reports name_valid low
// with every other field zero. Write the minimum digit counts only while
// the block is idle; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module tile_filename_parser_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// character side
	input  logic                               push,
	output logic                               full,
	input  logic [tfp_pkg::CHAR_W-1:0]         character,
	input  logic                               last_char,
	// result side
	output logic                               empty,
	input  logic                               pop,
	output logic                               name_valid,
	output logic [tfp_pkg::LOD_W-1:0]          lod_value,
	output logic signed [tfp_pkg::COORD_W-1:0] easting_value,
	output logic signed [tfp_pkg::COORD_W-1:0] northing_value,
	output logic [1:0]                         file_kind,
	// configuration
	input  logic                               cfg_write,
	input  logic [tfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfp_pkg::MIN_W-1:0]          cfg_data
);

	tfp_pkg::class_t   word;
	logic              avail;
	logic              take;
	logic              res_full;
	logic              res_put;
	tfp_pkg::result_t  res;
	tfp_pkg::result_t  res_head;
	tfp_pkg::cfg_wr_t  cfg;

	assign cfg.write = cfg_write;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// front: classify and queue characters
	tfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.character (character),
		.last_char (last_char),
		.word      (word),
		.avail     (avail),
		.take      (take)
	);

	// back: parse state, holds off only when a result has no room
	tfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.word     (word),
		.avail    (avail),
		.take     (take),
		.res_full (res_full),
		.res_put  (res_put),
		.res      (res)
	);

	// results wait here for the consumer
	tfp_out_queue u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.put     (res_put),
		.res_in  (res),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.res_out (res_head)
	);

	assign name_valid     = res_head.valid;
	assign lod_value      = res_head.lod;
	assign easting_value  = res_head.east;
	assign northing_value = res_head.north;
	assign file_kind      = res_head.kind;

endmodule
